### sv/segmented_binary_loader_core_macros.svh
`ifndef SEGMENTED_BINARY_LOADER_CORE_MACROS_SVH
`define SEGMENTED_BINARY_LOADER_CORE_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define SBL_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SBL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/sbl_pkg.sv
`default_nettype none

package sbl_pkg;

   localparam logic [7:0] MARKER_BYTE = 8'hFF;
   localparam int RSP_ADDR_BITS = 16;

   typedef enum logic [2:0] {
      PH_HEAD  = 3'd0,
      PH_START = 3'd1,
      PH_END   = 3'd2,
      PH_DATA  = 3'd3,
      PH_DROP  = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      ST_BUSY         = 3'd0,
      ST_DONE         = 3'd1,
      ST_BAD_HEADER   = 3'd2,
      ST_SHORT_HEADER = 3'd3,
      ST_SHORT_PAIR   = 3'd4,
      ST_BAD_RANGE    = 3'd5,
      ST_SHORT_DATA   = 3'd6
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_file;
   } req_type;

   typedef struct packed {
      logic                     write_enable;
      logic [RSP_ADDR_BITS-1:0] write_address;
      logic [7:0]               write_data;
      status_type               status;
   } rsp_type;

   // handshake state between the result register and the parser
   typedef struct packed {
      logic take;
      logic can_take;
   } flow_type;

endpackage

`default_nettype wire

### sv/segmented_binary_loader_core.sv
// Segmented load-file parser. One file byte enters per req beat, flagged on the file's last
// byte; every byte yields exactly one rsp beat carrying a memory write (for segment data) and
// a status: busy, done, or the first error of the file, after which bytes are dropped with
// busy status up to the flagged end. The block takes one byte per clock: the per-byte state
// update sits between the parser state registers and a single result register, and a byte is
// taken whenever that register is empty or being drained, and its rsp beat follows next cycle.
// ADDRESS_BITS (8 to 32) sets the address field size, one byte per started 8 bits.
`default_nettype none

module segmented_binary_loader_core #(
   parameter int ADDRESS_BITS = 16
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  sbl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output sbl_pkg::rsp_type rsp_data
);
   import sbl_pkg::*;

   flow_type flow;
   rsp_type  result;

   sbl_parser #(
      .ADDRESS_BITS(ADDRESS_BITS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .flow    (flow),
      .req_beat(req_data),
      .result  (result)
   );

   sbl_rsp_reg u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .result   (result),
      .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .flow     (flow)
   );

   assign req_ready = flow.can_take;

endmodule

`default_nettype wire

### sv/sbl_parser.sv
`default_nettype none

module sbl_parser #(
   parameter int ADDRESS_BITS = 16
) (
   input  wire              clock,
   input  wire              reset,
   input  sbl_pkg::flow_type flow,
   input  sbl_pkg::req_type req_beat,
   output sbl_pkg::rsp_type result
);
   import sbl_pkg::*;

   localparam int FB = (ADDRESS_BITS + 7) / 8;
   localparam int FW = 8 * FB;
   localparam logic [FW-1:0] ADDR_MASK = FW'((64'd1 << ADDRESS_BITS) - 64'd1);

   phase_type                phase_ff, phase_in;
   logic [7:0]               held_ff, held_in;
   logic [1:0]               pair_ff, pair_in;
   logic [FW-1:0]            start_ff, start_in;
   logic [FW-1:0]            end_ff, end_in;
   logic [ADDRESS_BITS-1:0]  next_ff, next_in;

   logic [7:0]               b;
   logic                     eof;
   logic [4:0]               shift;
   logic [FW-1:0]            start_acc, end_acc;
   logic                     field_last, head_ok, start_marker, range_bad, data_last;
   status_type               status;
   logic [31:0]              addr_wide;

   assign b            = req_beat.data_byte;
   assign eof          = req_beat.end_of_file;
   assign shift        = {pair_ff, 3'b000};
   assign start_acc    = start_ff | (FW'(b) << shift);
   assign end_acc      = end_ff | (FW'(b) << shift);
   assign field_last   = (pair_ff == 2'(FB - 1));
   assign head_ok      = (held_ff == MARKER_BYTE) && (b == MARKER_BYTE);
   assign start_marker = (start_acc == {FW{1'b1}});
   assign range_bad    = (start_ff[ADDRESS_BITS-1:0] >= end_acc[ADDRESS_BITS-1:0]);
   assign data_last    = (next_ff >= end_ff[ADDRESS_BITS-1:0]);
   assign addr_wide    = 32'(next_ff);

   // result for the beat at the input
   always_comb begin
      status = ST_BUSY;
      result.write_enable  = 1'b0;
      result.write_address = '0;
      result.write_data    = '0;
      case (phase_ff)
         PH_HEAD: begin
            if (pair_ff == 2'd0) begin
               if (eof) status = ST_SHORT_HEADER;
            end else if (!head_ok) begin
               status = ST_BAD_HEADER;
            end else if (eof) begin
               status = ST_DONE;
            end
         end
         PH_START: begin
            if (eof) status = (field_last && start_marker) ? ST_DONE : ST_SHORT_PAIR;
         end
         PH_END: begin
            if (field_last && range_bad) status = ST_BAD_RANGE;
            else if (eof)                status = field_last ? ST_SHORT_DATA : ST_SHORT_PAIR;
         end
         PH_DATA: begin
            result.write_enable  = 1'b1;
            result.write_address = addr_wide[RSP_ADDR_BITS-1:0];
            result.write_data    = b;
            if (eof) status = data_last ? ST_DONE : ST_SHORT_DATA;
         end
         default: begin
         end
      endcase
      result.status = status;
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      pair_in  = pair_ff;
      start_in = start_ff;
      end_in   = end_ff;
      next_in  = next_ff;
      case (phase_ff)
         PH_HEAD: begin
            if (pair_ff == 2'd0) begin
               held_in = b;
               pair_in = 2'd1;
            end else begin
               pair_in = 2'd0;
               if (head_ok) begin
                  phase_in = PH_START;
                  start_in = '0;
               end
            end
         end
         PH_START: begin
            start_in = start_acc;
            pair_in  = pair_ff + 2'd1;
            if (field_last) begin
               pair_in = 2'd0;
               if (start_marker) begin
                  start_in = '0;
               end else begin
                  phase_in = PH_END;
                  end_in   = '0;
               end
            end
         end
         PH_END: begin
            end_in  = end_acc;
            pair_in = pair_ff + 2'd1;
            if (field_last) begin
               pair_in  = 2'd0;
               start_in = start_ff & ADDR_MASK;
               end_in   = end_acc & ADDR_MASK;
               if (!range_bad) begin
                  phase_in = PH_DATA;
                  next_in  = start_ff[ADDRESS_BITS-1:0];
               end
            end
         end
         PH_DATA: begin
            if (data_last) begin
               phase_in = PH_START;
               start_in = '0;
            end else begin
               next_in = next_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (status >= ST_BAD_HEADER) phase_in = PH_DROP;
      // final beat of a file: next beat opens a new file
      if (eof) begin
         phase_in = PH_HEAD;
         held_in  = '0;
         pair_in  = '0;
         start_in = '0;
         end_in   = '0;
         next_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEAD;
         held_ff  <= '0;
         pair_ff  <= '0;
         start_ff <= '0;
         end_ff   <= '0;
         next_ff  <= '0;
      end else if (flow.take) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         pair_ff  <= pair_in;
         start_ff <= start_in;
         end_ff   <= end_in;
         next_ff  <= next_in;
      end
   end

endmodule

`default_nettype wire

### sv/sbl_rsp_reg.sv
`default_nettype none

module sbl_rsp_reg (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   input  sbl_pkg::rsp_type  result,
   input  wire               rsp_ready,
   output logic              rsp_valid,
   output sbl_pkg::rsp_type  rsp_data,
   output sbl_pkg::flow_type flow
);
   import sbl_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // a new beat may enter whenever the register is empty or the held result leaves this cycle
   assign flow.can_take = !valid_ff || rsp_ready;
   assign flow.take     = req_valid && flow.can_take;
   assign valid_in      = flow.take || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (flow.take) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

### sv/sbl_checker.sv
`default_nettype none
`include "segmented_binary_loader_core_macros.svh"

module sbl_checker (
   input wire              clock,
   input wire              reset,
   input wire              req_valid,
   input wire              req_ready,
   input wire              rsp_valid,
   input wire              rsp_ready,
   input sbl_pkg::rsp_type rsp_data
);
   import sbl_pkg::*;

   `SBL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp beat changed while stalled")
   `SBL_ASSERT_NEXT(a_req_gives_rsp, clock, reset, req_valid && req_ready, rsp_valid, "accepted byte produced no rsp beat")
   `SBL_ASSERT_SAME(a_idle_fields_zero, clock, reset, rsp_valid && !rsp_data.write_enable, rsp_data.write_address == '0 && rsp_data.write_data == '0, "non-write beat carries address or data")
   `SBL_ASSERT_SAME(a_write_status, clock, reset, rsp_valid && rsp_data.write_enable, rsp_data.status == ST_BUSY || rsp_data.status == ST_DONE || rsp_data.status == ST_SHORT_DATA, "write beat with header or range error status")

endmodule

bind segmented_binary_loader_core sbl_checker u_sbl_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);

`default_nettype wire
